// ----- rtl/scsa_pkg.sv -----
`timescale 1ns / 1ps
package scsa_pkg;

   typedef enum logic [3:0] {
      CMD_FIRED_ENTRY = 4'd0,
      CMD_FIRED_COUNT = 4'd1,
      CMD_DELAY_START = 4'd2,
      CMD_DELAY_COUNT = 4'd3,
      CMD_SYNAPSE     = 4'd4,
      CMD_WEIGHT      = 4'd5,
      CMD_RUN         = 4'd6,
      CMD_READ        = 4'd7,
      CMD_CLEAR       = 4'd8
   } cmd_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC,
      S_READ,
      S_DIV,
      S_TS0,
      S_OFF,
      S_CNT,
      S_FIRE,
      S_NID,
      S_DLY,
      S_SYN,
      S_SD,
      S_ACC,
      S_RESP
   } state_type;

   localparam logic [1:0] CSR_MIN_DELAY     = 2'd0;
   localparam logic [1:0] CSR_MAX_DELAY     = 2'd1;
   localparam logic [1:0] CSR_NEURON_COUNT  = 2'd2;
   localparam logic [1:0] CSR_SYNAPSE_COUNT = 2'd3;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_SYN_ERR = 2'd1;
   localparam logic [1:0] STATUS_SAT     = 2'd2;

   localparam int WEIGHT_AW    = 16;
   localparam int WEIGHT_DEPTH = 65536;

endpackage

// ----- rtl/scsa_if.sv -----
`timescale 1ns / 1ps
interface scsa_req_if;
   logic               valid;
   logic               ready;
   logic [3:0]         cmd;
   logic [3:0]         slot;
   logic [15:0]        index;
   logic signed [31:0] value;
   logic [15:0]        weight_index;
   logic [30:0]        time_step;

   modport source (output valid, cmd, slot, index, value, weight_index, time_step,
                   input ready);
   modport sink (input valid, cmd, slot, index, value, weight_index, time_step,
                 output ready);
endinterface

interface scsa_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] read_data;
   logic               done_res;
   logic [1:0]         status;

   modport source (output valid, read_data, done_res, status, input ready);
   modport sink (input valid, read_data, done_res, status, output ready);
endinterface

// ----- rtl/scsa_ram.sv -----
`timescale 1ns / 1ps
module scsa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ----- rtl/scsa_moddiv.sv -----
`timescale 1ns / 1ps
module scsa_moddiv (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [30:0] dividend,
   input  logic [4:0]  divisor,
   output logic        done,
   output logic [4:0]  rem
);
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [30:0] sh_ff, sh_in;
   logic [4:0]  rem_ff, rem_in;
   logic [4:0]  div_ff, div_in;
   logic [5:0]  trial;

   // Restoring remainder, one dividend bit per cycle.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      sh_in   = sh_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      trial   = {rem_ff, sh_ff[30]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 5'd0;
         sh_in   = dividend;
         rem_in  = 5'd0;
         div_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = 5'(trial - {1'b0, div_ff});
         end else begin
            rem_in = 5'(trial);
         end
         sh_in  = {sh_ff[29:0], 1'b0};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd30) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      sh_ff  <= sh_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;
endmodule

// ----- rtl/scsa_satadd.sv -----
`timescale 1ns / 1ps
module scsa_satadd (
   input  logic [31:0] acc,
   input  logic [31:0] addend,
   output logic [31:0] sum,
   output logic        sat
);
   logic [32:0] wide;

   always_comb begin
      wide = {acc[31], acc} + {addend[31], addend};
      sat  = wide[32] != wide[31];
      if (sat) begin
         sum = wide[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
         sum = wide[31:0];
      end
   end
endmodule

// ----- rtl/spike_synapse_current_accumulator_unit.sv -----
`timescale 1ns / 1ps
// Load, clear and unknown commands go from the execute state to the response; a read of a
// valid neuron also passes the read state. A run waits for the remainder unit, then walks
// each delay offset, each fired neuron and each synapse, adding into a valid destination.
// One command at a time; a run is bound by the single current memory read-modify-write.
// Reset is synchronous; afterwards a clearing pass zeroes the currents and no beat is
// taken until it ends (configuration writes are taken meanwhile).
module spike_synapse_current_accumulator_unit #(
   parameter int NEURONS     = 1024,
   parameter int SYNAPSES    = 65536,
   parameter int DELAY_SLOTS = 16,
   parameter int FIRED_CAP   = 256
) (
   input  logic        clock,
   input  logic        reset,
   scsa_req_if.sink    req_bus,
   scsa_rsp_if.source  rsp_bus,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [16:0] csr_wdata
);
   localparam int NB   = $clog2(NEURONS);
   localparam int SB   = (SYNAPSES > 1) ? $clog2(SYNAPSES) : 1;
   localparam int SCW  = $clog2(SYNAPSES + 1);
   localparam int LW   = (SCW > 17) ? SCW : 17;
   localparam int FCW  = $clog2(FIRED_CAP + 1);
   localparam int DSW  = (DELAY_SLOTS > 1) ? $clog2(DELAY_SLOTS) : 1;
   localparam int FLD  = DELAY_SLOTS * FIRED_CAP;
   localparam int FLW  = (FLD > 1) ? $clog2(FLD) : 1;
   localparam int DLD  = DELAY_SLOTS * NEURONS;
   localparam int DLW  = $clog2(DLD);
   localparam int SYNW = scsa_pkg::WEIGHT_AW + NB + 1;

   scsa_pkg::state_type state_ff, state_next;
   scsa_pkg::cmd_type   cmd_ff, cmd_in;

   logic [3:0]  slot_ff, slot_in;
   logic [15:0] index_ff, index_in;
   logic [31:0] value_ff, value_in;
   logic [15:0] widx_ff, widx_in;
   logic [30:0] time_ff, time_in;

   logic [3:0]  min_ff, max_ff;
   logic [10:0] ncount_ff;
   logic [16:0] scount_ff;

   logic [NB-1:0]  clr_ff, clr_in;
   logic [4:0]     len_ff, len_in, ring_ff, ring_in, ts_ff, ts_in, d_ff, d_in;
   logic [FCW-1:0] fcnt_ff, fcnt_in, fi_ff, fi_in;
   logic [SCW-1:0] sid_ff, sid_in, left_ff, left_in;
   logic [NB-1:0]  dst_ff, dst_in;
   logic           err_ff, err_in, sat_ff, sat_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff, rsp_data_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;

   logic           fc_we;
   logic [DSW-1:0] fc_waddr, fc_raddr;
   logic [FCW-1:0] fc_wdata, fc_rdata;
   logic           fl_we;
   logic [FLW-1:0] fl_waddr, fl_raddr;
   logic [NB:0]    fl_wdata, fl_rdata;
   logic           ds_we, dc_we;
   logic [DLW-1:0] dl_waddr, dl_raddr;
   logic [SCW-1:0] dl_wdata, ds_rdata, dc_rdata;
   logic           syn_we;
   logic [SB-1:0]  syn_waddr, syn_raddr;
   logic [SYNW-1:0] syn_wdata, syn_rdata;
   logic           w_we;
   logic [scsa_pkg::WEIGHT_AW-1:0] w_waddr, w_raddr;
   logic [31:0]    w_rdata;
   logic           cur_we;
   logic [NB-1:0]  cur_waddr, cur_raddr;
   logic [31:0]    cur_wdata, cur_rdata;

   logic        div_start, div_done;
   logic [4:0]  div_rem;
   logic [31:0] add_sum;
   logic        add_sat;

   logic        slot_ok, idx_neuron_ok, run_skip, offset_ok, nid_ok, dst_ok;
   logic [5:0]  ts_sum;
   logic [LW-1:0]  limit_wide;
   logic [SCW-1:0] limit, avail, valid_cnt;

   scsa_ram #(.WIDTH(FCW), .DEPTH(DELAY_SLOTS), .AW(DSW)) u_fired_count (
      .clock(clock), .we(fc_we), .waddr(fc_waddr), .wdata(fc_wdata),
      .raddr(fc_raddr), .rdata(fc_rdata));
   scsa_ram #(.WIDTH(NB + 1), .DEPTH(FLD), .AW(FLW)) u_fired_list (
      .clock(clock), .we(fl_we), .waddr(fl_waddr), .wdata(fl_wdata),
      .raddr(fl_raddr), .rdata(fl_rdata));
   scsa_ram #(.WIDTH(SCW), .DEPTH(DLD), .AW(DLW)) u_delay_start (
      .clock(clock), .we(ds_we), .waddr(dl_waddr), .wdata(dl_wdata),
      .raddr(dl_raddr), .rdata(ds_rdata));
   scsa_ram #(.WIDTH(SCW), .DEPTH(DLD), .AW(DLW)) u_delay_count (
      .clock(clock), .we(dc_we), .waddr(dl_waddr), .wdata(dl_wdata),
      .raddr(dl_raddr), .rdata(dc_rdata));
   scsa_ram #(.WIDTH(SYNW), .DEPTH(SYNAPSES), .AW(SB)) u_synapse (
      .clock(clock), .we(syn_we), .waddr(syn_waddr), .wdata(syn_wdata),
      .raddr(syn_raddr), .rdata(syn_rdata));
   scsa_ram #(.WIDTH(32), .DEPTH(scsa_pkg::WEIGHT_DEPTH), .AW(scsa_pkg::WEIGHT_AW))
      u_weight (
      .clock(clock), .we(w_we), .waddr(w_waddr), .wdata(value_ff),
      .raddr(w_raddr), .rdata(w_rdata));
   scsa_ram #(.WIDTH(32), .DEPTH(NEURONS), .AW(NB)) u_current (
      .clock(clock), .we(cur_we), .waddr(cur_waddr), .wdata(cur_wdata),
      .raddr(cur_raddr), .rdata(cur_rdata));

   // The ring size is taken in the same cycle that the remainder unit starts.
   scsa_moddiv u_moddiv (
      .clock(clock), .reset(reset), .start(div_start), .dividend(time_ff),
      .divisor(ring_in), .done(div_done), .rem(div_rem));

   scsa_satadd u_satadd (
      .acc(cur_rdata), .addend(w_rdata), .sum(add_sum), .sat(add_sat));

   always_comb begin
      slot_ok       = 7'(slot_ff) < 7'(DELAY_SLOTS);
      idx_neuron_ok = 17'(index_ff) < 17'(NEURONS);
      run_skip      = max_ff < min_ff;
      offset_ok     = (7'(ts_ff) < 7'(DELAY_SLOTS)) && (7'(d_ff) < 7'(DELAY_SLOTS));
      nid_ok        = !fl_rdata[NB] && (17'(fl_rdata[NB-1:0]) < 17'(ncount_ff));
      dst_ok        = !syn_rdata[NB];
      ts_sum        = 6'(div_rem) + 6'(len_ff);
      limit_wide    = (LW'(scount_ff) < LW'(SYNAPSES)) ? LW'(scount_ff) : LW'(SYNAPSES);
      limit         = SCW'(limit_wide);
      avail         = (ds_rdata < limit) ? (limit - ds_rdata) : '0;
      valid_cnt     = (avail < dc_rdata) ? avail : dc_rdata;
   end

   always_comb begin
      state_next = state_ff;
      case (state_ff)
         scsa_pkg::S_CLEAR: if (clr_ff == NB'(NEURONS - 1)) state_next = scsa_pkg::S_IDLE;
         scsa_pkg::S_IDLE:  if (req_bus.valid) state_next = scsa_pkg::S_EXEC;
         scsa_pkg::S_EXEC: begin
            case (cmd_ff)
               scsa_pkg::CMD_RUN:
                  state_next = run_skip ? scsa_pkg::S_RESP : scsa_pkg::S_DIV;
               scsa_pkg::CMD_READ:
                  state_next = idx_neuron_ok ? scsa_pkg::S_READ : scsa_pkg::S_RESP;
               default: state_next = scsa_pkg::S_RESP;
            endcase
         end
         scsa_pkg::S_READ: state_next = scsa_pkg::S_RESP;
         scsa_pkg::S_DIV:  if (div_done) state_next = scsa_pkg::S_TS0;
         scsa_pkg::S_TS0:  state_next = scsa_pkg::S_OFF;
         scsa_pkg::S_OFF: begin
            if (d_ff == len_ff) state_next = scsa_pkg::S_RESP;
            else if (offset_ok) state_next = scsa_pkg::S_CNT;
         end
         scsa_pkg::S_CNT:  state_next = scsa_pkg::S_FIRE;
         scsa_pkg::S_FIRE:
            state_next = (fi_ff == fcnt_ff) ? scsa_pkg::S_OFF : scsa_pkg::S_NID;
         scsa_pkg::S_NID:  state_next = nid_ok ? scsa_pkg::S_DLY : scsa_pkg::S_FIRE;
         scsa_pkg::S_DLY:  state_next = scsa_pkg::S_SYN;
         scsa_pkg::S_SYN:
            state_next = (left_ff == '0) ? scsa_pkg::S_FIRE : scsa_pkg::S_SD;
         scsa_pkg::S_SD:   state_next = dst_ok ? scsa_pkg::S_ACC : scsa_pkg::S_SYN;
         scsa_pkg::S_ACC:  state_next = scsa_pkg::S_SYN;
         scsa_pkg::S_RESP: if (rsp_bus.ready) state_next = scsa_pkg::S_IDLE;
         default:          state_next = scsa_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd_in   = cmd_ff;
      slot_in  = slot_ff;
      index_in = index_ff;
      value_in = value_ff;
      widx_in  = widx_ff;
      time_in  = time_ff;
      clr_in   = clr_ff;
      len_in   = len_ff;
      ring_in  = ring_ff;
      ts_in    = ts_ff;
      d_in     = d_ff;
      fcnt_in  = fcnt_ff;
      fi_in    = fi_ff;
      sid_in   = sid_ff;
      left_in  = left_ff;
      dst_in   = dst_ff;
      err_in   = err_ff;
      sat_in   = sat_ff;
      rsp_valid_in  = state_next == scsa_pkg::S_RESP;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;

      fc_we     = 1'b0;
      fc_waddr  = DSW'(slot_ff);
      fc_wdata  = (value_ff > 32'(FIRED_CAP)) ? FCW'(FIRED_CAP) : FCW'(value_ff);
      fc_raddr  = DSW'(ts_ff);
      fl_we     = 1'b0;
      fl_waddr  = FLW'(slot_ff) * FLW'(FIRED_CAP) + FLW'(index_ff);
      fl_wdata  = {value_ff >= 32'(NEURONS), NB'(value_ff)};
      fl_raddr  = FLW'(ts_ff) * FLW'(FIRED_CAP) + FLW'(fi_ff);
      ds_we     = 1'b0;
      dc_we     = 1'b0;
      dl_waddr  = DLW'(slot_ff) * DLW'(NEURONS) + DLW'(index_ff);
      dl_wdata  = (value_ff >= 32'(SYNAPSES)) ? SCW'(SYNAPSES) : SCW'(value_ff);
      dl_raddr  = DLW'(d_ff) * DLW'(NEURONS) + DLW'(fl_rdata[NB-1:0]);
      syn_we    = 1'b0;
      syn_waddr = SB'(index_ff);
      syn_wdata = {widx_ff, value_ff >= 32'(NEURONS), NB'(value_ff)};
      syn_raddr = SB'(sid_ff);
      w_we      = 1'b0;
      w_waddr   = index_ff;
      w_raddr   = syn_rdata[SYNW-1:NB+1];
      cur_we    = 1'b0;
      cur_waddr = NB'(index_ff);
      cur_wdata = '0;
      cur_raddr = syn_rdata[NB-1:0];
      div_start = 1'b0;

      case (state_ff)
         scsa_pkg::S_CLEAR: begin
            cur_we    = 1'b1;
            cur_waddr = clr_ff;
            clr_in    = clr_ff + NB'(1);
         end
         scsa_pkg::S_IDLE: begin
            cmd_in   = scsa_pkg::cmd_type'(req_bus.cmd);
            slot_in  = req_bus.slot;
            index_in = req_bus.index;
            value_in = req_bus.value;
            widx_in  = req_bus.weight_index;
            time_in  = req_bus.time_step;
         end
         scsa_pkg::S_EXEC: begin
            rsp_data_in   = '0;
            rsp_status_in = scsa_pkg::STATUS_OK;
            case (cmd_ff)
               scsa_pkg::CMD_FIRED_ENTRY:
                  fl_we = slot_ok && (17'(index_ff) < 17'(FIRED_CAP));
               scsa_pkg::CMD_FIRED_COUNT: fc_we = slot_ok;
               scsa_pkg::CMD_DELAY_START: ds_we = slot_ok && idx_neuron_ok;
               scsa_pkg::CMD_DELAY_COUNT: dc_we = slot_ok && idx_neuron_ok;
               scsa_pkg::CMD_SYNAPSE:     syn_we = 25'(index_ff) < 25'(SYNAPSES);
               scsa_pkg::CMD_WEIGHT:      w_we = 1'b1;
               scsa_pkg::CMD_RUN: begin
                  div_start = !run_skip;
                  err_in    = 1'b0;
                  sat_in    = 1'b0;
                  len_in    = 5'(max_ff) - 5'(min_ff) + 5'd1;
                  ring_in   = 5'(max_ff) + 5'd1;
                  d_in      = 5'd0;
               end
               scsa_pkg::CMD_READ: cur_raddr = NB'(index_ff);
               scsa_pkg::CMD_CLEAR: cur_we = idx_neuron_ok;
               default: ;
            endcase
         end
         scsa_pkg::S_READ: rsp_data_in = cur_rdata;
         scsa_pkg::S_TS0: begin
            ts_in = (ts_sum >= 6'(ring_ff)) ? 5'(ts_sum - 6'(ring_ff)) : 5'(ts_sum);
         end
         scsa_pkg::S_OFF: begin
            if (d_ff == len_ff) begin
               rsp_status_in = err_ff ? scsa_pkg::STATUS_SYN_ERR :
                               (sat_ff ? scsa_pkg::STATUS_SAT : scsa_pkg::STATUS_OK);
            end else if (!offset_ok) begin
               d_in  = d_ff + 5'd1;
               ts_in = (ts_ff == 5'd0) ? ring_ff - 5'd1 : ts_ff - 5'd1;
            end
         end
         scsa_pkg::S_CNT: begin
            fcnt_in = fc_rdata;
            fi_in   = '0;
         end
         scsa_pkg::S_FIRE: begin
            // Once every fired neuron of this slot is done, the walk moves to the next offset.
            if (fi_ff == fcnt_ff) begin
               d_in  = d_ff + 5'd1;
               ts_in = (ts_ff == 5'd0) ? ring_ff - 5'd1 : ts_ff - 5'd1;
            end
         end
         scsa_pkg::S_NID: if (!nid_ok) fi_in = fi_ff + FCW'(1);
         scsa_pkg::S_DLY: begin
            sid_in  = ds_rdata;
            left_in = valid_cnt;
            if (valid_cnt < dc_rdata) err_in = 1'b1;
         end
         scsa_pkg::S_SYN: if (left_ff == '0) fi_in = fi_ff + FCW'(1);
         scsa_pkg::S_SD: begin
            dst_in = syn_rdata[NB-1:0];
            if (!dst_ok) begin
               sid_in  = sid_ff + SCW'(1);
               left_in = left_ff - SCW'(1);
            end
         end
         scsa_pkg::S_ACC: begin
            cur_we    = 1'b1;
            cur_waddr = dst_ff;
            cur_wdata = add_sum;
            sat_in    = sat_ff | add_sat;
            sid_in    = sid_ff + SCW'(1);
            left_in   = left_ff - SCW'(1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= scsa_pkg::S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         min_ff       <= 4'd0;
         max_ff       <= 4'd0;
         ncount_ff    <= 11'd1024;
         scount_ff    <= 17'd0;
      end else begin
         state_ff     <= state_next;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               scsa_pkg::CSR_MIN_DELAY:     min_ff    <= csr_wdata[3:0];
               scsa_pkg::CSR_MAX_DELAY:     max_ff    <= csr_wdata[3:0];
               scsa_pkg::CSR_NEURON_COUNT:  ncount_ff <= csr_wdata[10:0];
               scsa_pkg::CSR_SYNAPSE_COUNT: scount_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
      cmd_ff        <= cmd_in;
      slot_ff       <= slot_in;
      index_ff      <= index_in;
      value_ff      <= value_in;
      widx_ff       <= widx_in;
      time_ff       <= time_in;
      len_ff        <= len_in;
      ring_ff       <= ring_in;
      ts_ff         <= ts_in;
      d_ff          <= d_in;
      fcnt_ff       <= fcnt_in;
      fi_ff         <= fi_in;
      sid_ff        <= sid_in;
      left_ff       <= left_in;
      dst_ff        <= dst_in;
      err_ff        <= err_in;
      sat_ff        <= sat_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_bus.ready     = state_ff == scsa_pkg::S_IDLE;
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.read_data = rsp_data_ff;
   assign rsp_bus.done_res  = 1'b1;
   assign rsp_bus.status    = rsp_status_ff;

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_bus.ready && rsp_bus.valid))
      else $error("request taken while a response is pending");

   a_cur_write: assert property (@(posedge clock) disable iff (reset)
      cur_we |-> (state_ff == scsa_pkg::S_CLEAR || state_ff == scsa_pkg::S_EXEC ||
                  state_ff == scsa_pkg::S_ACC))
      else $error("current memory written outside clear, command or accumulate");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == scsa_pkg::S_DIV)
      else $error("remainder finished outside the wait state");

   a_run_status: assert property (@(posedge clock) disable iff (reset)
      (state_ff == scsa_pkg::S_DLY && valid_cnt < dc_rdata) |=>
         (err_ff && state_ff == scsa_pkg::S_SYN))
      else $error("synapse range error not recorded");
endmodule

// ----- verif/tb_spike_synapse_current_accumulator_unit.sv -----
`timescale 1ns / 1ps
module tb_spike_synapse_current_accumulator_unit;

   typedef struct {
      logic [3:0]  cmd;
      logic [3:0]  slot;
      logic [15:0] index;
      logic [31:0] value;
      logic [15:0] widx;
      logic [30:0] tstep;
   } syn_cmd_type;

   typedef struct {
      logic signed [31:0] rd;
      logic               done;
      logic [1:0]         status;
   } syn_rsp_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [16:0] csr_wdata;

   scsa_req_if req_ch ();
   scsa_rsp_if rsp_ch ();

   spike_synapse_current_accumulator_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_ch),
      .rsp_bus   (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the block's state, with a flag per table entry telling whether it was loaded.
   logic [31:0]        fired_ids [16][256];
   logic [31:0]        fired_num [16];
   logic [31:0]        dly_start [16][1024];
   logic [31:0]        dly_count [16][1024];
   logic [31:0]        syn_dst   [65536];
   logic [15:0]        syn_wid   [65536];
   logic signed [31:0] weights   [65536];
   logic signed [31:0] currents  [1024];
   bit fired_ids_ok [16][256];
   bit fired_num_ok [16];
   bit dly_start_ok [16][1024];
   bit dly_count_ok [16][1024];
   bit syn_ok       [65536];
   bit weight_ok    [65536];

   int unsigned cfg_min, cfg_max, cfg_neurons, cfg_synapses;
   syn_rsp_type pending [$];
   int          errors;
   int          rsp_wait;
   bit          steady;

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   initial begin
      #40_000_000;
      $display("TEST FAILED");
      $finish;
   end

   task automatic report(string msg);
      $display("mismatch: %s", msg);
      errors++;
   endtask

   // Response side: random stalls, mostly short, with some long ones.
   always @(posedge clock) begin
      if (reset || steady) begin
         rsp_ch.ready <= 1'b1;
         rsp_wait = 0;
      end else if (rsp_wait == 0) begin
         int r;
         r = $urandom_range(0, 99);
         if (r < 70) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= 1'b0;
            rsp_wait = (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
         end
      end else begin
         rsp_wait--;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         syn_rsp_type e;
         if (pending.size() == 0) begin
            report("response beat with nothing outstanding");
         end else begin
            e = pending.pop_front();
            if (rsp_ch.read_data !== e.rd)
               report($sformatf("read_data %h, wanted %h", rsp_ch.read_data, e.rd));
            if (rsp_ch.done_res !== e.done)
               report($sformatf("done_res %b, wanted %b", rsp_ch.done_res, e.done));
            if (rsp_ch.status !== e.status)
               report($sformatf("status %0d, wanted %0d", rsp_ch.status, e.status));
         end
      end
   end

   function automatic syn_cmd_type rand_cmd();
      syn_cmd_type c;
      c.cmd   = 4'($urandom_range(0, 15));
      c.slot  = 4'($urandom_range(0, 15));
      c.index = 16'($urandom);
      c.value = $urandom;
      c.widx  = 16'($urandom);
      c.tstep = 31'($urandom);
      return c;
   endfunction

   function automatic logic [31:0] pick_neuron();
      return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 7) : $urandom;
   endfunction

   function automatic logic [15:0] pick_wid();
      return ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 15)) : 16'($urandom);
   endfunction

   function automatic logic [31:0] pick_weight();
      if ($urandom_range(0, 9) < 8)
         return $urandom_range(0, 32'h60000) - 32'h30000;
      return $urandom;
   endfunction

   function automatic logic [31:0] pick_start(longint unsigned lim);
      int r;
      r = $urandom_range(0, 99);
      if (lim == 0 || r < 15)
         return (r < 8) ? $urandom_range(0, 8) : $urandom;
      if (r < 65)
         return $urandom_range(0, (lim < 32) ? int'(lim) - 1 : 31);
      return $urandom_range(0, int'(lim) - 1);
   endfunction

   // Walks one time step. With apply clear it only looks for the first entry that the
   // step would read before it was loaded (or that would make the step too long) and
   // returns a load for it; with apply set it adds the weights and gives the status.
   function automatic bit walk_step(input logic [30:0] tstep, input bit apply,
                                    input bit big_ok, output syn_cmd_type fix,
                                    output logic [1:0] st);
      longint unsigned lim, len, ring, d, slot, n, i, start, cnt, vld, j, sid;
      logic [31:0] nid, dst;
      logic [15:0] wid;
      longint      s;
      bit          err, sat;
      err = 0;
      sat = 0;
      st  = scsa_pkg::STATUS_OK;
      fix = rand_cmd();
      lim = (cfg_synapses < 65536) ? cfg_synapses : 65536;
      if (cfg_max < cfg_min)
         return 0;
      len  = cfg_max - cfg_min + 1;
      ring = cfg_max + 1;
      for (d = 0; d < len; d++) begin
         slot = (tstep + len - d) % ring;
         n = fired_num[slot];
         if (!fired_num_ok[slot] || (!apply && !big_ok && n > 4)) begin
            fix.cmd = scsa_pkg::CMD_FIRED_COUNT;
            fix.slot = 4'(slot);
            fix.value = $urandom_range(0, 3);
            return 1;
         end
         for (i = 0; i < n; i++) begin
            if (!fired_ids_ok[slot][i]) begin
               fix.cmd = scsa_pkg::CMD_FIRED_ENTRY;
               fix.slot = 4'(slot);
               fix.index = 16'(i);
               fix.value = pick_neuron();
               return 1;
            end
            nid = fired_ids[slot][i];
            if (nid >= cfg_neurons || nid >= 1024)
               continue;
            if (!dly_start_ok[d][nid]) begin
               fix.cmd = scsa_pkg::CMD_DELAY_START;
               fix.slot = 4'(d);
               fix.index = 16'(nid);
               fix.value = pick_start(lim);
               return 1;
            end
            start = dly_start[d][nid];
            cnt = dly_count[d][nid];
            vld = 0;
            if (start < lim)
               vld = (lim - start < cnt) ? lim - start : cnt;
            if (!dly_count_ok[d][nid] || (!apply && vld > 4)) begin
               fix.cmd = scsa_pkg::CMD_DELAY_COUNT;
               fix.slot = 4'(d);
               fix.index = 16'(nid);
               fix.value = $urandom_range(0, 4);
               return 1;
            end
            if (vld < cnt)
               err = 1;
            for (j = 0; j < vld; j++) begin
               sid = start + j;
               if (!syn_ok[sid]) begin
                  fix.cmd = scsa_pkg::CMD_SYNAPSE;
                  fix.index = 16'(sid);
                  fix.value = pick_neuron();
                  fix.widx = pick_wid();
                  return 1;
               end
               dst = syn_dst[sid];
               wid = syn_wid[sid];
               if (dst >= 1024)
                  continue;
               if (!weight_ok[wid]) begin
                  fix.cmd = scsa_pkg::CMD_WEIGHT;
                  fix.index = wid;
                  fix.value = pick_weight();
                  return 1;
               end
               if (apply) begin
                  s = longint'(currents[dst]) + longint'(weights[wid]);
                  if (s > 64'sd2147483647) begin
                     currents[dst] = 32'h7fffffff;
                     sat = 1;
                  end else if (s < -64'sd2147483648) begin
                     currents[dst] = 32'h80000000;
                     sat = 1;
                  end else begin
                     currents[dst] = s[31:0];
                  end
               end
            end
         end
      end
      st = err ? scsa_pkg::STATUS_SYN_ERR :
           (sat ? scsa_pkg::STATUS_SAT : scsa_pkg::STATUS_OK);
      return 0;
   endfunction

   function automatic syn_rsp_type predict_result(syn_cmd_type c);
      syn_rsp_type r;
      syn_cmd_type unused;
      r.rd = '0;
      r.done = 1'b1;
      r.status = scsa_pkg::STATUS_OK;
      case (scsa_pkg::cmd_type'(c.cmd))
         scsa_pkg::CMD_FIRED_ENTRY: if (c.index < 256) begin
            fired_ids[c.slot][c.index] = c.value;
            fired_ids_ok[c.slot][c.index] = 1;
         end
         scsa_pkg::CMD_FIRED_COUNT: begin
            fired_num[c.slot] = (c.value > 256) ? 256 : c.value;
            fired_num_ok[c.slot] = 1;
         end
         scsa_pkg::CMD_DELAY_START: if (c.index < 1024) begin
            dly_start[c.slot][c.index] = c.value;
            dly_start_ok[c.slot][c.index] = 1;
         end
         scsa_pkg::CMD_DELAY_COUNT: if (c.index < 1024) begin
            dly_count[c.slot][c.index] = (c.value > 65536) ? 65536 : c.value;
            dly_count_ok[c.slot][c.index] = 1;
         end
         scsa_pkg::CMD_SYNAPSE: begin
            syn_dst[c.index] = c.value;
            syn_wid[c.index] = c.widx;
            syn_ok[c.index] = 1;
         end
         scsa_pkg::CMD_WEIGHT: begin
            weights[c.index] = c.value;
            weight_ok[c.index] = 1;
         end
         scsa_pkg::CMD_RUN: void'(walk_step(c.tstep, 1, 1, unused, r.status));
         scsa_pkg::CMD_READ: if (c.index < 1024) r.rd = currents[c.index];
         scsa_pkg::CMD_CLEAR: if (c.index < 1024) currents[c.index] = '0;
         default: ;
      endcase
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      if (steady)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      return (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
   endfunction

   task automatic send_beat(syn_cmd_type c);
      int gap;
      syn_rsp_type e;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.cmd          <= c.cmd;
      req_ch.slot         <= c.slot;
      req_ch.index        <= c.index;
      req_ch.value        <= c.value;
      req_ch.weight_index <= c.widx;
      req_ch.time_step    <= c.tstep;
      e = predict_result(c);
      do @(posedge clock); while (!req_ch.ready);
      pending.push_back(e);
   endtask

   task automatic send_fields(logic [3:0] cmd, logic [3:0] slot, logic [15:0] index,
                              logic [31:0] value, logic [15:0] widx = 16'd0);
      syn_cmd_type c;
      c = rand_cmd();
      c.cmd = cmd;
      c.slot = slot;
      c.index = index;
      c.value = value;
      c.widx = widx;
      send_beat(c);
   endtask

   // Loads whatever the step would read unloaded, then issues the run itself.
   task automatic run_step(logic [30:0] tstep, bit big_ok = 0);
      syn_cmd_type fix, c;
      logic [1:0] st;
      while (walk_step(tstep, 0, big_ok, fix, st))
         send_beat(fix);
      c = rand_cmd();
      c.cmd = scsa_pkg::CMD_RUN;
      c.tstep = tstep;
      send_beat(c);
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending.size() != 0);
   endtask

   task automatic write_config(int unsigned mn, int unsigned mx, int unsigned nc,
                               int unsigned sc);
      drain_results();
      repeat (4) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= scsa_pkg::CSR_MIN_DELAY;
      csr_wdata <= 17'(mn);
      @(posedge clock);
      csr_index <= scsa_pkg::CSR_MAX_DELAY;
      csr_wdata <= 17'(mx);
      @(posedge clock);
      csr_index <= scsa_pkg::CSR_NEURON_COUNT;
      csr_wdata <= 17'(nc);
      @(posedge clock);
      csr_index <= scsa_pkg::CSR_SYNAPSE_COUNT;
      csr_wdata <= 17'(sc);
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_min = mn;
      cfg_max = mx;
      cfg_neurons = nc;
      cfg_synapses = sc;
   endtask

   task automatic test_loads_and_reads();
      write_config(2, 5, 1024, 16);
      send_fields(scsa_pkg::CMD_WEIGHT, 4'd0, 16'd0, 32'h0001_0000);
      send_fields(scsa_pkg::CMD_WEIGHT, 4'd0, 16'hffff, 32'h8000_0000);
      send_fields(scsa_pkg::CMD_WEIGHT, 4'd0, 16'd1, 32'h7fff_ffff);
      send_fields(scsa_pkg::CMD_FIRED_ENTRY, 4'd15, 16'd255, 32'd3);
      send_fields(scsa_pkg::CMD_FIRED_ENTRY, 4'd15, 16'd256, 32'd3);
      send_fields(scsa_pkg::CMD_DELAY_START, 4'd15, 16'd1023, 32'd0);
      send_fields(scsa_pkg::CMD_DELAY_START, 4'd15, 16'd1024, 32'd0);
      send_fields(scsa_pkg::CMD_DELAY_COUNT, 4'd15, 16'hffff, 32'd1);
      send_fields(scsa_pkg::CMD_SYNAPSE, 4'd0, 16'hffff, 32'd1023, 16'd1);
      send_fields(4'd9, 4'd0, 16'd0, 32'd0);
      send_fields(4'd15, 4'd15, 16'hffff, 32'hffff_ffff);
      send_fields(scsa_pkg::CMD_READ, 4'd0, 16'd1023, 32'd0);
      send_fields(scsa_pkg::CMD_READ, 4'd0, 16'hffff, 32'd0);
      send_fields(scsa_pkg::CMD_CLEAR, 4'd0, 16'hffff, 32'd0);
   endtask

   task automatic test_run_basic();
      run_step(31'd0);
      run_step(31'h7fff_ffff);
      send_fields(scsa_pkg::CMD_READ, 4'd0, 16'd0, 32'd0);
   endtask

   task automatic test_count_limits();
      write_config(0, 0, 4, 65536);
      send_fields(scsa_pkg::CMD_FIRED_ENTRY, 4'd0, 16'd0, 32'd0);
      send_fields(scsa_pkg::CMD_DELAY_START, 4'd0, 16'd0, 32'd65533);
      send_fields(scsa_pkg::CMD_DELAY_COUNT, 4'd0, 16'd0, 32'h8000_0005);
      send_fields(scsa_pkg::CMD_FIRED_COUNT, 4'd0, 16'd0, 32'd300);
      run_step(31'd7, 1);
      send_fields(scsa_pkg::CMD_FIRED_COUNT, 4'd0, 16'd0, 32'd1);
      run_step(31'd8);
   endtask

   task automatic test_saturation();
      send_fields(scsa_pkg::CMD_WEIGHT, 4'd0, 16'd7, 32'h7fff_ffff);
      send_fields(scsa_pkg::CMD_SYNAPSE, 4'd0, 16'd100, 32'd5, 16'd7);
      send_fields(scsa_pkg::CMD_SYNAPSE, 4'd0, 16'd101, 32'd5, 16'd7);
      send_fields(scsa_pkg::CMD_DELAY_START, 4'd0, 16'd0, 32'd100);
      send_fields(scsa_pkg::CMD_DELAY_COUNT, 4'd0, 16'd0, 32'd2);
      run_step(31'd1);
      send_fields(scsa_pkg::CMD_READ, 4'd0, 16'd5, 32'd0);
      send_fields(scsa_pkg::CMD_CLEAR, 4'd0, 16'd5, 32'd0);
      send_fields(scsa_pkg::CMD_READ, 4'd0, 16'd5, 32'd0);
   endtask

   task automatic test_inverted_delays();
      write_config(9, 3, 1024, 65536);
      run_step(31'd4);
   endtask

   task automatic test_random_traffic(int unsigned count, bit hold_mid);
      syn_cmd_type c;
      int r;
      for (int k = 0; k < count; k++) begin
         if (hold_mid && k == count / 2)
            drain_results();
         r = $urandom_range(0, 99);
         if (r < 30) begin
            run_step((r < 15) ? 31'($urandom_range(0, 40)) : 31'($urandom));
         end else begin
            c = rand_cmd();
            if (r < 50) begin
               c.cmd = scsa_pkg::CMD_READ;
            end else if (r < 55) begin
               c.cmd = scsa_pkg::CMD_CLEAR;
            end else if (r < 60) begin
               c.cmd = 4'($urandom_range(9, 15));
            end else begin
               c.cmd = 4'($urandom_range(0, 5));
               if ($urandom_range(0, 9) < 7)
                  c.index = 16'($urandom_range(0, 7));
               case (scsa_pkg::cmd_type'(c.cmd))
                  scsa_pkg::CMD_FIRED_ENTRY: c.value = pick_neuron();
                  scsa_pkg::CMD_FIRED_COUNT, scsa_pkg::CMD_DELAY_COUNT:
                     if ($urandom_range(0, 9) < 7) c.value = $urandom_range(0, 4);
                  scsa_pkg::CMD_DELAY_START: c.value = pick_start(cfg_synapses);
                  scsa_pkg::CMD_SYNAPSE: begin
                     c.value = pick_neuron();
                     if ($urandom_range(0, 9) < 7) c.widx = pick_wid();
                  end
                  default: c.value = pick_weight();
               endcase
            end
            if ((c.cmd == scsa_pkg::CMD_READ || c.cmd == scsa_pkg::CMD_CLEAR) &&
                $urandom_range(0, 9) < 8)
               c.index = 16'($urandom_range(0, 7));
            send_beat(c);
         end
      end
   endtask

   initial begin
      errors = 0;
      steady = 0;
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= scsa_pkg::CSR_MIN_DELAY;
      csr_wdata <= '0;
      req_ch.valid <= 1'b0;
      req_ch.cmd <= '0;
      req_ch.slot <= '0;
      req_ch.index <= '0;
      req_ch.value <= '0;
      req_ch.weight_index <= '0;
      req_ch.time_step <= '0;
      cfg_min = 0;
      cfg_max = 0;
      cfg_neurons = 1024;
      cfg_synapses = 0;
      foreach (currents[n]) currents[n] = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_loads_and_reads();
      test_run_basic();
      test_count_limits();
      test_saturation();
      test_inverted_delays();

      write_config(15, 15, 1024, 65536);
      test_random_traffic(160, 1);
      write_config(0, 15, 1, 0);
      test_random_traffic(160, 0);
      write_config(0, 0, 1024, 65535);
      steady = 1;
      test_random_traffic(120, 0);
      steady = 0;
      write_config(3, 7, 6, 300);
      test_random_traffic(160, 0);
      for (int p = 0; p < 3; p++) begin
         write_config($urandom_range(0, 15), $urandom_range(0, 15),
                      $urandom_range(1, 1024), $urandom_range(0, 65536));
         test_random_traffic(160, 0);
      end

      drain_results();
      repeat (50) @(posedge clock);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
